[rtl/sqlp_pkg.sv]
// ----------------------------------------------------------------------------
// sqlp_pkg
// shared types and constants for the signal quality line parser
// ----------------------------------------------------------------------------
package sqlp_pkg;

  localparam int CH_W  = 8;
  localparam int ACC_W = 7;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_C     = 8'h43;
  localparam logic [CH_W-1:0] CH_S     = 8'h53;
  localparam logic [CH_W-1:0] CH_Q     = 8'h51;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;

  localparam logic [ACC_W-1:0] ACC_SAT  = 7'd100;
  localparam logic [ACC_W-1:0] RSSI_MAX = 7'd31;
  localparam logic [ACC_W-1:0] BER_MAX  = 7'd7;
  localparam logic [ACC_W-1:0] CODE_UNK = 7'd99;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            line_end;
  } item_t;

  typedef struct packed {
    logic [ACC_W-1:0] ber;
    logic [ACC_W-1:0] rssi;
    logic             valid_res;
  } res_t;

  typedef enum logic [12:0] {
    PH_P0    = 13'b0000000000001,
    PH_P1    = 13'b0000000000010,
    PH_P2    = 13'b0000000000100,
    PH_P3    = 13'b0000000001000,
    PH_P4    = 13'b0000000010000,
    PH_SP1   = 13'b0000000100000,
    PH_RSSI  = 13'b0000001000000,
    PH_COMMA = 13'b0000010000000,
    PH_SP2   = 13'b0000100000000,
    PH_BER   = 13'b0001000000000,
    PH_TAIL  = 13'b0010000000000,
    PH_BAD   = 13'b0100000000000,
    PH_DONE  = 13'b1000000000000
  } phase_t;

  // acc * 10 + d, saturated
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ACC_W{1'b0}}, d};
    acc_digit = (v >= {4'b0000, ACC_SAT}) ? ACC_SAT : v[ACC_W-1:0];
  endfunction

endpackage

[rtl/signal_quality_line_parser_core.sv]
// ----------------------------------------------------------------------------
// signal_quality_line_parser_core
// result: the input register's line end word loads the result register
// throughput: one word per cycle unless a line end word stalls on output
//   back pressure, set by the single-step parse between the two registers
// reset: synchronous, clears the parse state, accumulators and both valids
// ----------------------------------------------------------------------------
module signal_quality_line_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // valid_res, rssi, ber, zero pad
);
  import sqlp_pkg::*;

  logic  in_valid;
  item_t item;
  logic  step;
  logic  load;
  res_t  res;
  res_t  out_res;

  assign load     = in_valid && item.line_end && (!m_tvalid || m_tready);
  assign step     = in_valid && (!item.line_end || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.ch       <= s_tdata;
      item.line_end <= s_tlast;
    end
  end

  sqlp_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.ber, out_res.rssi, out_res.valid_res};

`ifndef NO_ASSERTIONS
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |->
      ((m_tdata[7:1] <= RSSI_MAX || m_tdata[7:1] == CODE_UNK)
       && (m_tdata[14:8] <= BER_MAX || m_tdata[14:8] == CODE_UNK)))
    else $error("result out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[15:1] == 15'd0))
    else $error("invalid result carries data");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && item.line_end && m_tvalid && !m_tready))
    else $error("input stalled without output back pressure");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("line end result not presented");
`endif

endmodule

[rtl/sqlp_fsm.sv]
// ----------------------------------------------------------------------------
// sqlp_fsm
// parse state, digit accumulators and line result for one registered word
// ----------------------------------------------------------------------------
module sqlp_fsm (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  sqlp_pkg::item_t item,
  output sqlp_pkg::res_t  res
);
  import sqlp_pkg::*;

  phase_t           phase, phase_next;
  logic [ACC_W-1:0] rssi_acc, rssi_acc_next;
  logic [ACC_W-1:0] ber_acc, ber_acc_next;
  logic             is_digit;
  logic [3:0]       d;
  logic [CH_W-1:0]  dch;
  logic             ok;

  assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign dch      = item.ch - CH_ZERO;
  assign d        = dch[3:0];

  always_comb begin
    phase_next    = phase;
    rssi_acc_next = rssi_acc;
    ber_acc_next  = ber_acc;
    if (phase == PH_BAD || phase == PH_DONE) begin
      phase_next = phase;
    end else if (item.ch == CH_NUL) begin
      phase_next = (phase == PH_BER || phase == PH_TAIL) ? PH_DONE : PH_BAD;
    end else begin
      case (phase)
        PH_P0: phase_next = (item.ch == CH_PLUS)  ? PH_P1  : PH_BAD;
        PH_P1: phase_next = (item.ch == CH_C)     ? PH_P2  : PH_BAD;
        PH_P2: phase_next = (item.ch == CH_S)     ? PH_P3  : PH_BAD;
        PH_P3: phase_next = (item.ch == CH_Q)     ? PH_P4  : PH_BAD;
        PH_P4: phase_next = (item.ch == CH_COLON) ? PH_SP1 : PH_BAD;
        PH_SP1, PH_RSSI: begin
          if (is_digit) begin
            rssi_acc_next = acc_digit(rssi_acc, d);
            phase_next    = PH_RSSI;
          end else if (item.ch == CH_SPACE) begin
            phase_next = (phase == PH_SP1) ? PH_SP1 : PH_COMMA;
          end else if (item.ch == CH_COMMA && phase == PH_RSSI) begin
            phase_next = PH_SP2;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_COMMA: begin
          if (item.ch == CH_COMMA) begin
            phase_next = PH_SP2;
          end else if (item.ch != CH_SPACE) begin
            phase_next = PH_BAD;
          end
        end
        PH_SP2, PH_BER: begin
          if (is_digit) begin
            ber_acc_next = acc_digit(ber_acc, d);
            phase_next   = PH_BER;
          end else if (item.ch == CH_SPACE) begin
            phase_next = (phase == PH_SP2) ? PH_SP2 : PH_TAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_TAIL: begin
          if (item.ch != CH_SPACE) begin
            phase_next = PH_BAD;
          end
        end
        default: phase_next = PH_BAD;
      endcase
    end
  end

  assign ok = (phase == PH_BER || phase == PH_TAIL || phase == PH_DONE)
              && (rssi_acc <= RSSI_MAX || rssi_acc == CODE_UNK)
              && (ber_acc <= BER_MAX || ber_acc == CODE_UNK);

  assign res.valid_res = ok;
  assign res.rssi      = ok ? rssi_acc : '0;
  assign res.ber       = ok ? ber_acc : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_P0;
      rssi_acc <= '0;
      ber_acc  <= '0;
    end else if (step) begin
      if (item.line_end) begin
        phase    <= PH_P0;
        rssi_acc <= '0;
        ber_acc  <= '0;
      end else begin
        phase    <= phase_next;
        rssi_acc <= rssi_acc_next;
        ber_acc  <= ber_acc_next;
      end
    end
  end

endmodule
